// ===== design/pmes_pkg.sv =====
`default_nettype none
package pmes_pkg;

	localparam int IntervalW = 16;
	localparam int AttemptW  = 8;
	localparam int CfgAddrW  = 3;
	localparam int CfgDataW  = 16;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_COMM = 2'd1,
		MODE_FAST = 2'd2,
		MODE_REG  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [CfgAddrW-1:0] {
		REG_COMM_INTERVAL = 3'd0,
		REG_FAST_INTERVAL = 3'd1,
		REG_REG_INTERVAL  = 3'd2,
		REG_COMM_MAX      = 3'd3,
		REG_FAST_MAX      = 3'd4,
		REG_REG_MAX       = 3'd5,
		REG_SPARE6        = 3'd6,
		REG_SPARE7        = 3'd7
	} reg_idx_t;

	localparam logic [IntervalW-1:0] COMM_INTERVAL_RST = 16'd250;
	localparam logic [IntervalW-1:0] FAST_INTERVAL_RST = 16'd250;
	localparam logic [IntervalW-1:0] REG_INTERVAL_RST  = 16'd1000;
	localparam logic [AttemptW-1:0]  COMM_MAX_RST      = 8'd50;
	localparam logic [AttemptW-1:0]  FAST_MAX_RST      = 8'd3;
	localparam logic [AttemptW-1:0]  REG_MAX_RST       = 8'd3;
	localparam logic [AttemptW-1:0]  ATTEMPT_SAT       = 8'd255;

	typedef struct packed {
		logic [IntervalW-1:0] comm_interval;
		logic [IntervalW-1:0] fast_interval;
		logic [IntervalW-1:0] reg_interval;
		logic [AttemptW-1:0]  comm_max;
		logic [AttemptW-1:0]  fast_max;
		logic [AttemptW-1:0]  reg_max;
	} cfg_t;

	typedef struct packed {
		logic                running;
		logic                sleep_allowed;
		logic [AttemptW-1:0] attempt_count;
		mode_t               current_mode;
		logic                poll_now;
	} result_t;

endpackage
`default_nettype wire

// ===== design/pmes_cfg.sv =====
`default_nettype none
module pmes_cfg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [pmes_pkg::CfgAddrW-1:0] cfg_addr,
	input  wire  [pmes_pkg::CfgDataW-1:0] cfg_data,
	output pmes_pkg::cfg_t               cfg
);
	import pmes_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.comm_interval <= COMM_INTERVAL_RST;
			cfg_q.fast_interval <= FAST_INTERVAL_RST;
			cfg_q.reg_interval  <= REG_INTERVAL_RST;
			cfg_q.comm_max      <= COMM_MAX_RST;
			cfg_q.fast_max      <= FAST_MAX_RST;
			cfg_q.reg_max       <= REG_MAX_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_COMM_INTERVAL: cfg_q.comm_interval <= cfg_data;
				REG_FAST_INTERVAL: cfg_q.fast_interval <= cfg_data;
				REG_REG_INTERVAL:  cfg_q.reg_interval  <= cfg_data;
				REG_COMM_MAX:      cfg_q.comm_max      <= cfg_data[AttemptW-1:0];
				REG_FAST_MAX:      cfg_q.fast_max      <= cfg_data[AttemptW-1:0];
				REG_REG_MAX:       cfg_q.reg_max       <= cfg_data[AttemptW-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/pmes_core.sv =====
`default_nettype none
module pmes_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           step,
	input  pmes_pkg::req_t                req,
	input  wire  [1:0]                    start_mode,
	input  pmes_pkg::cfg_t                cfg,
	output pmes_pkg::result_t             res
);
	import pmes_pkg::*;

	mode_t                mode_q, mode_d, start_m, tick_mode;
	logic [AttemptW-1:0]  att_q, att_d, att_inc, att_tick, mx;
	logic [IntervalW-1:0] cnt_q, cnt_d, start_iv, tick_iv;
	logic                 poll;

	function automatic logic [IntervalW-1:0] interval_of(mode_t m, cfg_t c);
		logic [IntervalW-1:0] v;
		unique case (m)
			MODE_COMM: v = c.comm_interval;
			MODE_FAST: v = c.fast_interval;
			default:   v = c.reg_interval;
		endcase
		return (v == '0) ? IntervalW'(1) : v;
	endfunction

	always_comb begin
		unique case (start_mode)
			2'd0:    start_m = MODE_COMM;
			2'd1:    start_m = MODE_FAST;
			default: start_m = MODE_REG;
		endcase
		start_iv = interval_of(start_m, cfg);

		unique case (mode_q)
			MODE_COMM: mx = cfg.comm_max;
			MODE_FAST: mx = cfg.fast_max;
			default:   mx = cfg.reg_max;
		endcase
		att_inc = att_q + 1'b1;
		if (att_inc == ATTEMPT_SAT)
			att_inc = mx + 1'b1;
		tick_mode = mode_q;
		att_tick  = att_inc;
		if (mx != '0 && att_inc >= mx) begin
			if (mode_q == MODE_COMM) begin
				tick_mode = MODE_FAST;
				att_tick  = '0;
			end else if (mode_q == MODE_FAST) begin
				tick_mode = MODE_REG;
				att_tick  = '0;
			end
		end
		tick_iv = interval_of(tick_mode, cfg);

		mode_d = mode_q;
		att_d  = att_q;
		cnt_d  = cnt_q;
		poll   = 1'b0;
		unique case (req)
			REQ_START: begin
				mode_d = start_m;
				att_d  = '0;
				cnt_d  = start_iv;
			end
			REQ_STOP: begin
				mode_d = MODE_IDLE;
				att_d  = '0;
				cnt_d  = '0;
			end
			REQ_CLEAR: begin
				if (mode_q != MODE_IDLE)
					att_d = '0;
			end
			default: begin
				if (mode_q != MODE_IDLE) begin
					if (cnt_q > IntervalW'(1)) begin
						cnt_d = cnt_q - 1'b1;
					end else begin
						poll   = 1'b1;
						mode_d = tick_mode;
						att_d  = att_tick;
						cnt_d  = tick_iv;
					end
				end
			end
		endcase

		res.poll_now      = poll;
		res.current_mode  = mode_d;
		res.attempt_count = att_d;
		res.sleep_allowed = (mode_d == MODE_IDLE) ||
		                    (mode_d == MODE_REG && att_d >= cfg.reg_max);
		res.running       = (mode_d != MODE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			att_q  <= '0;
			cnt_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			att_q  <= att_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/poll_mode_escalation_scheduler.sv =====
`default_nettype none
// Poll scheduler with commissioning, fast and regular modes. Each event on the
// slave stream (tick, start, stop, clear attempts) yields exactly one result on
// the master stream. An event is registered on entry and its result is built
// from that register and then registered at the output, so one event is taken
// every cycle while the master side keeps up; the next event is still accepted
// while a result waits on a stalled master side. Configuration writes are taken
// at any time but are meant to be issued only while no event is in flight.
module poll_mode_escalation_scheduler (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire  [7:0]                     s_axis_tdata,  // [1:0] start_mode
	input  wire  [1:0]                     s_axis_tuser,  // [1:0] req_type
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	// [0] poll_now, [2:1] current_mode, [10:3] attempt_count,
	// [11] sleep_allowed, [12] running
	output logic [15:0]                    m_axis_tdata,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [pmes_pkg::CfgAddrW-1:0]  cfg_addr,
	input  wire  [pmes_pkg::CfgDataW-1:0]  cfg_data
);
	import pmes_pkg::*;

	cfg_t    cfg;
	result_t res;
	logic    valid_s1, advance;
	req_t    req_s1;
	logic [1:0] mode_s1;
	logic    out_valid_q;
	result_t out_q;

	pmes_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pmes_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.req        (req_s1),
		.start_mode (mode_s1),
		.cfg        (cfg),
		.res        (res)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= req_t'(s_axis_tuser);
			mode_s1 <= s_axis_tdata[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import pmes_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;   // [1:0] start_mode
	logic [1:0]          s_axis_tuser;   // [1:0] req_type
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// [0] poll_now, [2:1] current_mode, [10:3] attempt_count,
	// [11] sleep_allowed, [12] running
	logic [15:0]         m_axis_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgAddrW-1:0] cfg_addr;
	logic [CfgDataW-1:0] cfg_data;

	poll_mode_escalation_scheduler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	typedef struct {
		req_t        req;
		logic [1:0]  sm;
		bit          reconf;
		bit          known;
		result_t     want;
	} dir_row_t;

	// scheduler shadow state and registers
	logic [IntervalW-1:0] sh_comm_iv, sh_fast_iv, sh_reg_iv;
	logic [AttemptW-1:0]  sh_comm_max, sh_fast_max, sh_reg_max;
	mode_t                sh_mode;
	logic [AttemptW-1:0]  sh_attempts;
	logic [IntervalW-1:0] sh_countdown;

	result_t pending_results[$];
	int      n_bad;
	int      idle_cycles;
	bit      tx_burst;
	bit      rx_burst;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [IntervalW-1:0] interval_for(input mode_t m);
		logic [IntervalW-1:0] v;
		if (m == MODE_COMM)
			v = sh_comm_iv;
		else if (m == MODE_FAST)
			v = sh_fast_iv;
		else
			v = sh_reg_iv;
		return (v == '0) ? IntervalW'(1) : v;
	endfunction

	function automatic result_t schedule_event(input req_t r, input logic [1:0] sm);
		result_t             res;
		logic [AttemptW-1:0] mx;
		res = '0;
		case (r)
			REQ_START: begin
				sh_mode      = (sm == 2'd3) ? MODE_REG : mode_t'(sm + 2'd1);
				sh_attempts  = '0;
				sh_countdown = interval_for(sh_mode);
			end
			REQ_STOP: begin
				if (sh_mode != MODE_IDLE) begin
					sh_mode      = MODE_IDLE;
					sh_attempts  = '0;
					sh_countdown = '0;
				end
			end
			REQ_CLEAR: begin
				if (sh_mode != MODE_IDLE)
					sh_attempts = '0;
			end
			default: begin
				if (sh_mode != MODE_IDLE) begin
					if (sh_countdown > 1) begin
						sh_countdown = sh_countdown - 1'b1;
					end else begin
						mx = (sh_mode == MODE_COMM) ? sh_comm_max :
						     (sh_mode == MODE_FAST) ? sh_fast_max : sh_reg_max;
						res.poll_now = 1'b1;
						sh_attempts = sh_attempts + 1'b1;
						if (sh_attempts == ATTEMPT_SAT)
							sh_attempts = mx + 1'b1;
						if (mx != '0 && sh_attempts >= mx) begin
							if (sh_mode == MODE_COMM) begin
								sh_mode     = MODE_FAST;
								sh_attempts = '0;
							end else if (sh_mode == MODE_FAST) begin
								sh_mode     = MODE_REG;
								sh_attempts = '0;
							end
						end
						sh_countdown = interval_for(sh_mode);
					end
				end
			end
		endcase
		res.current_mode  = sh_mode;
		res.attempt_count = sh_attempts;
		res.sleep_allowed = (sh_mode == MODE_IDLE) ||
		                    (sh_mode == MODE_REG && sh_attempts >= sh_reg_max);
		res.running       = (sh_mode != MODE_IDLE);
		return res;
	endfunction

	task automatic cmp_field(input string fname, input int want, input int got);
		if (want != got) begin
			n_bad++;
			$display("%0t %s: expected %0d, got %0d", $time, fname, want, got);
		end
	endtask

	task automatic check_result(input logic [15:0] d);
		result_t got;
		result_t want;
		got = result_t'(d[12:0]);
		if (pending_results.size() == 0) begin
			n_bad++;
			$display("%0t result transfer with nothing expected: %h", $time, d);
		end else begin
			want = pending_results.pop_front();
			cmp_field("poll_now", want.poll_now, got.poll_now);
			cmp_field("current_mode", want.current_mode, got.current_mode);
			cmp_field("attempt_count", want.attempt_count, got.attempt_count);
			cmp_field("sleep_allowed", want.sleep_allowed, got.sleep_allowed);
			cmp_field("running", want.running, got.running);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] ci, input logic [15:0] fi,
	                           input logic [15:0] ri, input logic [7:0] cm,
	                           input logic [7:0] fm, input logic [7:0] rm);
		reg_idx_t    order [6];
		logic [15:0] vals [6];
		bit          rdy;
		order = '{REG_COMM_INTERVAL, REG_FAST_INTERVAL, REG_REG_INTERVAL,
		          REG_COMM_MAX, REG_FAST_MAX, REG_REG_MAX};
		vals  = '{ci, fi, ri, {8'd0, cm}, {8'd0, fm}, {8'd0, rm}};
		drain();
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_addr  <= order[i];
			cfg_data  <= vals[i];
			do begin
				@(negedge clk);
				rdy = cfg_ready;
				@(posedge clk);
			end while (!rdy);
			case (order[i])
				REG_COMM_INTERVAL: sh_comm_iv  = vals[i];
				REG_FAST_INTERVAL: sh_fast_iv  = vals[i];
				REG_REG_INTERVAL:  sh_reg_iv   = vals[i];
				REG_COMM_MAX:      sh_comm_max = vals[i][7:0];
				REG_FAST_MAX:      sh_fast_max = vals[i][7:0];
				REG_REG_MAX:       sh_reg_max  = vals[i][7:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		tx_burst = ($urandom_range(0, 2) == 0);
		rx_burst = ($urandom_range(0, 2) == 0);
	endtask

	task automatic send_event(input req_t r, input logic [1:0] sm, input bit known,
	                          input result_t want);
		int      gap;
		bit      rdy;
		result_t predicted;
		gap = tx_burst ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r;
		s_axis_tdata  <= {6'd0, sm};
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
		predicted = schedule_event(r, sm);
		pending_results.push_back(known ? want : predicted);
	endtask

	task automatic random_events(input int n, input int tick_pct);
		req_t r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 49) == 0)
				drain();
			if ($urandom_range(0, 99) < tick_pct)
				r = REQ_TICK;
			else
				r = req_t'($urandom_range(1, 3));
			send_event(r, 2'($urandom_range(0, 3)), 1'b0, '0);
		end
	endtask

	// result side
	initial begin
		int          stall;
		bit          got;
		logic [15:0] d;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(negedge clk);
				got = m_axis_tvalid;
				d   = m_axis_tdata;
				@(posedge clk);
			end while (!got);
			check_result(d);
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t rows[$];
		result_t  idle_res;
		logic [15:0] iv [3];
		logic [7:0]  mx [3];

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_TICK;
		cfg_valid     = 1'b0;
		cfg_addr      = REG_COMM_INTERVAL;
		cfg_data      = '0;
		n_bad         = 0;
		idle_cycles   = 0;
		tx_burst      = 1'b0;
		rx_burst      = 1'b0;

		sh_comm_iv   = COMM_INTERVAL_RST;
		sh_fast_iv   = FAST_INTERVAL_RST;
		sh_reg_iv    = REG_INTERVAL_RST;
		sh_comm_max  = COMM_MAX_RST;
		sh_fast_max  = FAST_MAX_RST;
		sh_reg_max   = REG_MAX_RST;
		sh_mode      = MODE_IDLE;
		sh_attempts  = '0;
		sh_countdown = '0;

		// field order: running, sleep_allowed, attempt_count, current_mode, poll_now
		idle_res = '{1'b0, 1'b1, 8'd0, MODE_IDLE, 1'b0};
		rows.push_back('{REQ_TICK,  2'd0, 1'b0, 1'b1, idle_res});
		rows.push_back('{REQ_STOP,  2'd3, 1'b0, 1'b1, idle_res});
		rows.push_back('{REQ_CLEAR, 2'd1, 1'b0, 1'b1, idle_res});
		rows.push_back('{REQ_START, 2'd3, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, MODE_REG, 1'b0}});
		rows.push_back('{REQ_TICK,  2'd2, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, MODE_REG, 1'b0}});
		rows.push_back('{REQ_START, 2'd0, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, MODE_COMM, 1'b0}});
		rows.push_back('{REQ_START, 2'd1, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, MODE_FAST, 1'b0}});
		rows.push_back('{REQ_START, 2'd2, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd0, MODE_REG, 1'b0}});
		rows.push_back('{REQ_STOP,  2'd0, 1'b0, 1'b1, idle_res});
		// zero intervals, quick escalation
		rows.push_back('{REQ_START, 2'd0, 1'b1, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd3, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd0, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_CLEAR, 2'd2, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd1, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd0, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd0, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd2, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd0, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_CLEAR, 2'd0, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_START, 2'd3, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd1, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_STOP,  2'd2, 1'b0, 1'b0, '0});
		rows.push_back('{REQ_TICK,  2'd3, 1'b0, 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].reconf)
				load_config(16'd0, 16'd0, 16'd0, 8'd1, 8'd2, 8'd2);
			send_event(rows[i].req, rows[i].sm, rows[i].known, rows[i].want);
		end

		load_config(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
		            16'($urandom_range(0, 3)), 8'($urandom_range(0, 4)),
		            8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
		random_events(70, 75);

		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd254, 8'd254, 8'd254);
		random_events(25, 60);

		// long tick run: count saturates in the mode picked at random for the start
		load_config(16'd1, 16'd1, 16'd1, 8'd0, 8'd0, 8'd254);
		send_event(REQ_START, 2'($urandom_range(0, 3)), 1'b0, '0);
		random_events(262, 100);

		for (int k = 0; k < 3; k++) begin
			iv[k] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) :
			                                      16'($urandom_range(0, 5));
			mx[k] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 254)) :
			                                      8'($urandom_range(0, 6));
		end
		load_config(iv[0], iv[1], iv[2], mx[0], mx[1], mx[2]);
		random_events(70, 80);

		load_config(16'd2, 16'd3, 16'd5, 8'd3, 8'd3, 8'd3);
		random_events(30, 75);

		drain();
		if (n_bad == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/pmes_pkg.sv
design/pmes_cfg.sv
design/pmes_core.sv
design/poll_mode_escalation_scheduler.sv
dv/tb.sv
